/* rtl/core/jfi_pkg.sv */
// Package for the joystick frame interposer: shared constants, reply tables,
// the frame job passed from front to back, and queue status. No dependencies.
package jfi_pkg;

  localparam int unsigned FrameLen = 10;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [IdxW-1:0] HsLen   = IdxW'(4);
  localparam logic [IdxW-1:0] AckLen  = IdxW'(6);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameLen - 1);

  localparam logic [7:0] HsOpcode   = 8'd116;
  localparam logic [7:0] CtrlHead   = 8'd96;
  localparam logic [7:0] CtrlMid    = 8'd128;
  localparam logic [7:0] CtrlMode   = 8'd132;
  localparam logic [7:0] CtrlTail   = 8'd15;
  localparam logic [7:0] FwdOfs     = 8'd192;
  localparam logic [7:0] GainOfs    = 8'd128;
  localparam logic [8:0] HumFwdOfs  = 9'd192;
  localparam logic [8:0] HumLeftOfs = 9'd192;
  localparam logic [7:0] HumGainOfs = 8'd128;
  // 283 mod 128: the checksum only keeps seven bits
  localparam logic [6:0] CsBase     = 7'd27;

  typedef logic [7:0] byte_t;

  localparam byte_t HsReply  [4] = '{8'd5, 8'd128, 8'd250, 8'd15};
  localparam byte_t AckReply [6] = '{8'd33, 8'd144, 8'd128, 8'd128, 8'd206, 8'd15};

  typedef struct packed {
    logic                       is_hs;
    logic [FrameLen-1:0][7:0]   ctrl;
    logic signed [8:0]          hum_fwd;
    logic signed [8:0]          hum_left;
    logic signed [7:0]          hum_gain;
  } job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  function automatic byte_t reply_byte(input logic is_hs, input logic [IdxW-1:0] idx);
    byte_t b;
    if (is_hs) begin
      b = HsReply[idx[1:0]];
    end else begin
      b = (idx[2:0] < 3'd6) ? AckReply[idx[2:0]] : AckReply[0];
    end
    return b;
  endfunction

endpackage

/* rtl/core/jfi_front.sv */
// Front part of the joystick frame interposer: counts link bytes into frames
// and builds one job per completed frame. Depends on jfi_pkg.
module jfi_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       rx_byte_i,
  input  logic             use_robot_i,
  input  logic signed [7:0] robot_forward_i,
  input  logic signed [7:0] robot_left_i,
  input  logic [6:0]       robot_gain_i,
  input  jfi_pkg::q_stat_t q_stat_i,
  output logic             job_push_o,
  output jfi_pkg::job_t    job_o
);
  import jfi_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  byte_t           store_q [FrameLen-1];
  logic            last_byte;
  logic            acc;
  logic [6:0]      cs_t;
  logic [6:0]      cs1;
  logic [6:0]      cs2;

  assign last_byte  = (idx_q == LastIdx);
  assign full       = last_byte && q_stat_i.full;
  assign acc        = push && !full;
  assign job_push_o = acc && last_byte;

  always_comb begin
    idx_d = idx_q;
    if (acc) begin
      idx_d = last_byte ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Hold the first nine bytes; the tenth is taken straight from the link.
  always_ff @(posedge clk_i) begin
    if (acc && !last_byte) begin
      store_q[idx_q] <= rx_byte_i;
    end
  end

  assign cs_t = CsBase + robot_left_i[6:0] - robot_forward_i[6:0] - robot_gain_i;
  assign cs1  = {1'b0, cs_t[6:1]};
  assign cs2  = cs_t - cs1;

  always_comb begin
    job_o          = '0;
    job_o.is_hs    = (store_q[0] == HsOpcode);
    job_o.hum_fwd  = $signed({1'b0, store_q[1]} - HumFwdOfs);
    job_o.hum_left = $signed(HumLeftOfs - {1'b0, store_q[2]});
    job_o.hum_gain = $signed(store_q[3] ^ HumGainOfs);
    if (use_robot_i) begin
      job_o.ctrl[0] = CtrlHead;
      job_o.ctrl[1] = robot_forward_i + FwdOfs;
      job_o.ctrl[2] = FwdOfs - robot_left_i;
      job_o.ctrl[3] = {1'b0, robot_gain_i} + GainOfs;
      job_o.ctrl[4] = {1'b1, cs1};
      job_o.ctrl[5] = CtrlMid;
      job_o.ctrl[6] = CtrlMode;
      job_o.ctrl[7] = CtrlMid;
      job_o.ctrl[8] = {1'b1, cs2};
      job_o.ctrl[9] = CtrlTail;
    end else begin
      for (int i = 0; i < FrameLen - 1; i++) begin
        job_o.ctrl[i] = store_q[i];
      end
      job_o.ctrl[FrameLen-1] = rx_byte_i;
    end
  end

endmodule

/* rtl/core/jfi_queue.sv */
// Short job queue between front and back of the joystick frame interposer.
// Depends on jfi_pkg.
module jfi_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jfi_pkg::job_t    job_i,
  input  logic             pop_i,
  output jfi_pkg::job_t    job_o,
  output jfi_pkg::q_stat_t stat_o
);
  import jfi_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  assign job_o        = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.valid = (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

/* rtl/core/jfi_back.sv */
// Back part of the joystick frame interposer: steps through one job, reply
// bytes then controller bytes, into the output register. Depends on jfi_pkg.
module jfi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jfi_pkg::job_t     job_i,
  input  jfi_pkg::q_stat_t  q_stat_i,
  output logic              q_pop_o,
  output logic              empty,
  input  logic              pop,
  output logic              dest_port_o,
  output logic [7:0]        tx_byte_o,
  output logic              run_last_o,
  output logic signed [8:0] human_forward_o,
  output logic signed [8:0] human_left_o,
  output logic signed [7:0] human_gain_o
);
  import jfi_pkg::*;

  job_t            job_q;
  logic            busy_q, busy_d;
  logic [IdxW-1:0] step_q, step_d;
  logic            out_valid_q, out_valid_d;
  logic [IdxW-1:0] reply_len;
  logic [IdxW-1:0] cidx;
  logic            in_reply;
  logic            last_step;
  logic            adv;
  byte_t           cur_byte;

  assign reply_len = job_q.is_hs ? HsLen : AckLen;
  assign in_reply  = (step_q < reply_len);
  assign cidx      = step_q - reply_len;
  assign last_step = (step_q == reply_len + LastIdx);
  assign cur_byte  = in_reply ? reply_byte(job_q.is_hs, step_q) : job_q.ctrl[cidx];
  assign adv       = busy_q && (!out_valid_q || pop);
  assign q_pop_o   = q_stat_i.valid && (!busy_q || (adv && last_step));
  assign empty     = !out_valid_q;

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
      step_d      = step_q + IdxW'(1);
      if (last_step) begin
        busy_d = 1'b0;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
    if (q_pop_o) begin
      busy_d = 1'b1;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= job_i;
    end
    if (adv) begin
      dest_port_o     <= !in_reply;
      tx_byte_o       <= cur_byte;
      run_last_o      <= last_step;
      human_forward_o <= job_q.hum_fwd;
      human_left_o    <= job_q.hum_left;
      human_gain_o    <= job_q.hum_gain;
    end
  end

endmodule

/* rtl/core/joystick_frame_interposer.sv */
// Top level of the joystick frame interposer: front, job queue and back.
// Depends on jfi_pkg, jfi_front, jfi_queue and jfi_back.
//
// Link bytes come in through a queue-style port (push/full) and are counted
// into 10-byte frames from reset; the byte count is not resynchronized by
// content. Use_robot and the robot_* fields are sampled with the tenth byte
// of a frame. For each frame the block delivers on the result port
// (empty/pop), oldest first, either a 4-byte handshake reply (first frame
// byte 116) or a 6-byte acknowledge to the joystick (dest_port 0), followed
// by 10 bytes to the controller (dest_port 1): the frame as received, or the
// robot control frame with its split 7-bit checksum. Run_last marks the last
// byte of each frame's run, and every byte carries the decoded human command
// of its frame. Rate: the front takes one byte per cycle unless full is up;
// the back emits one result byte per cycle while pop is held; a frame yields
// 14 or 16 result bytes. The job queue holds two finished frames; full rises
// only on a tenth byte while both slots are taken.
module joystick_frame_interposer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        rx_byte_i,
  input  logic              use_robot_i,
  input  logic signed [7:0] robot_forward_i,
  input  logic signed [7:0] robot_left_i,
  input  logic [6:0]        robot_gain_i,
  output logic              empty,
  input  logic              pop,
  output logic              dest_port_o,
  output logic [7:0]        tx_byte_o,
  output logic              run_last_o,
  output logic signed [8:0] human_forward_o,
  output logic signed [8:0] human_left_o,
  output logic signed [7:0] human_gain_o
);
  import jfi_pkg::*;

  job_t    front_job;
  job_t    q_job;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;

  // Classify bytes into frames and build a job on each tenth byte.
  jfi_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .rx_byte_i       (rx_byte_i),
    .use_robot_i     (use_robot_i),
    .robot_forward_i (robot_forward_i),
    .robot_left_i    (robot_left_i),
    .robot_gain_i    (robot_gain_i),
    .q_stat_i        (q_stat),
    .job_push_o      (q_push),
    .job_o           (front_job)
  );

  // Decouple front and back so each can stall on its own.
  jfi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (front_job),
    .pop_i  (q_pop),
    .job_o  (q_job),
    .stat_o (q_stat)
  );

  // Play out reply and controller bytes through the output register.
  jfi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (q_job),
    .q_stat_i        (q_stat),
    .q_pop_o         (q_pop),
    .empty           (empty),
    .pop             (pop),
    .dest_port_o     (dest_port_o),
    .tx_byte_o       (tx_byte_o),
    .run_last_o      (run_last_o),
    .human_forward_o (human_forward_o),
    .human_left_o    (human_left_o),
    .human_gain_o    (human_gain_o)
  );

`ifndef SYNTH
  // Front never writes a job into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // Back only takes a job that is there.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_stat.valid)
    else $error("job popped from empty queue");

  // A run always ends on a controller byte.
  a_last_to_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && run_last_o) |-> dest_port_o)
    else $error("run ends on a joystick byte");
`endif

endmodule

/* tb/jfi_frame_checker.sv */
// Frame checker for the joystick frame interposer: watches the request and
// result channels, predicts every reply and controller byte, and compares.
// Depends on jfi_pkg for the handshake opcode.
module jfi_frame_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              use_robot_i,
  input  logic signed [7:0] robot_forward_i,
  input  logic signed [7:0] robot_left_i,
  input  logic [6:0]        robot_gain_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  logic              dest_port_i,
  input  logic [7:0]        tx_byte_i,
  input  logic              run_last_i,
  input  logic signed [8:0] human_forward_i,
  input  logic signed [8:0] human_left_i,
  input  logic signed [7:0] human_gain_i,
  output int                fail_count_o,
  output int                outstanding_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              port;
    logic [7:0]        data;
    logic              last;
    logic signed [8:0] fwd;
    logic signed [8:0] left;
    logic signed [7:0] gain;
  } tx_rec_t;

  localparam logic [7:0] ShakeBytes [4] = '{8'd5, 8'd128, 8'd250, 8'd15};
  localparam logic [7:0] AckBytes   [6] = '{8'd33, 8'd144, 8'd128, 8'd128, 8'd206, 8'd15};
  localparam logic [7:0] HeadByte   = 8'd96;
  localparam logic [7:0] MidByte    = 8'd128;
  localparam logic [7:0] ModeByte   = 8'd132;
  localparam logic [7:0] TailByte   = 8'd15;
  localparam logic [7:0] Ofs192     = 8'd192;
  localparam logic [7:0] Ofs128     = 8'd128;
  localparam logic [6:0] SumBase    = 7'd27;  // 283 keeps only its low seven bits
  localparam int         FrameBytes = 10;

  logic [7:0] frame_buf [FrameBytes];
  int         slot;
  tx_rec_t    expected_tx [$];
  int         fails   = 0;
  int         checked = 0;

  // Queue up every byte that a completed frame produces, replies first.
  task automatic predict_frame(input logic robot, input logic [7:0] fwd,
                               input logic [7:0] left, input logic [6:0] gain);
    logic [7:0]        ctrl [FrameBytes];
    logic [6:0]        sum7, cs1, cs2;
    logic signed [8:0] hf, hl;
    logic signed [7:0] hg;
    hf = {1'b0, frame_buf[1]} - 9'd192;
    hl = 9'd192 - {1'b0, frame_buf[2]};
    hg = frame_buf[3] - Ofs128;
    if (frame_buf[0] == jfi_pkg::HsOpcode) begin
      for (int i = 0; i < 4; i++) expected_tx.push_back({1'b0, ShakeBytes[i], 1'b0, hf, hl, hg});
    end else begin
      for (int i = 0; i < 6; i++) expected_tx.push_back({1'b0, AckBytes[i], 1'b0, hf, hl, hg});
    end
    if (robot) begin
      sum7 = SumBase + left[6:0] - fwd[6:0] - gain;
      cs1  = sum7 >> 1;
      cs2  = sum7 - cs1;
      ctrl = '{HeadByte, fwd + Ofs192, Ofs192 - left, {1'b0, gain} + Ofs128,
               {1'b1, cs1}, MidByte, ModeByte, MidByte, {1'b1, cs2}, TailByte};
    end else begin
      ctrl = frame_buf;
    end
    for (int i = 0; i < FrameBytes; i++)
      expected_tx.push_back({1'b1, ctrl[i], i == FrameBytes - 1, hf, hl, hg});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tx_rec_t got, want;
    if (!rst_ni) begin
      slot = 0;
      expected_tx.delete();
    end else begin
      if (pop_i && !empty_i) begin
        got = {dest_port_i, tx_byte_i, run_last_i, human_forward_i, human_left_i, human_gain_i};
        if (expected_tx.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: port=%0d byte=%0d last=%0d", $time,
                   got.port, got.data, got.last);
        end else begin
          want = expected_tx.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: result %0d expected port=%0d byte=%0d last=%0d fwd=%0d left=%0d gain=%0d",
                     $time, checked, want.port, want.data, want.last, want.fwd, want.left,
                     want.gain);
            $display("%0t: result %0d actual   port=%0d byte=%0d last=%0d fwd=%0d left=%0d gain=%0d",
                     $time, checked, got.port, got.data, got.last, got.fwd, got.left, got.gain);
          end
          checked++;
        end
      end
      if (push_i && !full_i) begin
        frame_buf[slot] = rx_byte_i;
        if (slot == FrameBytes - 1) begin
          slot = 0;
          predict_frame(use_robot_i, robot_forward_i, robot_left_i, robot_gain_i);
        end else begin
          slot++;
        end
      end
    end
    fail_count_o  <= fails;
    outstanding_o <= expected_tx.size();
    checked_o     <= checked;
  end

endmodule

/* tb/joystick_frame_interposer_test.sv */
// Top of the joystick frame interposer regression: clock, reset, link byte
// requests and result pops with random idling. Depends on jfi_pkg,
// joystick_frame_interposer and jfi_frame_checker.
module joystick_frame_interposer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandFrames  = 40;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 32;
  localparam int FrameBytes  = 10;

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              push            = 1'b0;
  logic              full;
  logic [7:0]        rx_byte_i       = '0;
  logic              use_robot_i     = 1'b0;
  logic signed [7:0] robot_forward_i = '0;
  logic signed [7:0] robot_left_i    = '0;
  logic [6:0]        robot_gain_i    = '0;
  logic              empty;
  logic              pop             = 1'b0;
  logic              dest_port_o;
  logic [7:0]        tx_byte_o;
  logic              run_last_o;
  logic signed [8:0] human_forward_o;
  logic signed [8:0] human_left_o;
  logic signed [7:0] human_gain_o;

  int fail_count;
  int outstanding;
  int checked;
  int cycles      = 0;
  int pop_hold    = 0;
  int frames_sent = 0;
  int frames_hs   = 0;
  int frames_bot  = 0;
  // while set, neither the request side nor the result side idles
  bit steady      = 1'b0;

  joystick_frame_interposer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .rx_byte_i       (rx_byte_i),
    .use_robot_i     (use_robot_i),
    .robot_forward_i (robot_forward_i),
    .robot_left_i    (robot_left_i),
    .robot_gain_i    (robot_gain_i),
    .empty           (empty),
    .pop             (pop),
    .dest_port_o     (dest_port_o),
    .tx_byte_o       (tx_byte_o),
    .run_last_o      (run_last_o),
    .human_forward_o (human_forward_o),
    .human_left_o    (human_left_o),
    .human_gain_o    (human_gain_o)
  );

  jfi_frame_checker frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .rx_byte_i       (rx_byte_i),
    .use_robot_i     (use_robot_i),
    .robot_forward_i (robot_forward_i),
    .robot_left_i    (robot_left_i),
    .robot_gain_i    (robot_gain_i),
    .empty_i         (empty),
    .pop_i           (pop),
    .dest_port_i     (dest_port_o),
    .tx_byte_i       (tx_byte_o),
    .run_last_i      (run_last_o),
    .human_forward_i (human_forward_o),
    .human_left_i    (human_left_o),
    .human_gain_i    (human_gain_o),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding),
    .checked_o       (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then a long stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Link byte with extra weight on both ends and the middle of the range.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    if (r == 2) return 8'h80;
    return 8'($urandom_range(0, 255));
  endfunction

  // Hold a request until the block takes it, then maybe idle for a while.
  task automatic send_byte(input logic [7:0] b, input logic robot, input logic [7:0] fwd,
                           input logic [7:0] left, input logic [6:0] gain);
    int gap;
    push            <= 1'b1;
    rx_byte_i       <= b;
    use_robot_i     <= robot;
    robot_forward_i <= fwd;
    robot_left_i    <= left;
    robot_gain_i    <= gain;
    do @(posedge clk_i); while (full);
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Send one whole frame; the robot settings only count on the tenth byte, so
  // scramble them on the other nine to show they are ignored there.
  task automatic send_frame(input logic [7:0] bytes [FrameBytes], input logic robot,
                            input logic [7:0] fwd, input logic [7:0] left,
                            input logic [6:0] gain);
    for (int i = 0; i < FrameBytes - 1; i++)
      send_byte(bytes[i], 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    send_byte(bytes[FrameBytes - 1], robot, fwd, left, gain);
    frames_sent++;
    if (bytes[0] == jfi_pkg::HsOpcode) frames_hs++;
    if (robot) frames_bot++;
  endtask

  // Result side: pop whenever not stalled; pick a new stall after each accepted pop.
  always @(posedge clk_i or negedge rst_ni) begin
    int gap;
    if (!rst_ni) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
      pop      <= 1'b0;
    end else if (pop && !empty) begin
      gap = pick_gap();
      pop      <= (gap == 0);
      pop_hold <= (gap == 0) ? 0 : gap - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results still due", cycles, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] frm [FrameBytes];
    int         r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Handshake frame with alternating extreme bytes and the robot frame at
    // full negative forward, full positive left and top gain.
    frm = '{jfi_pkg::HsOpcode, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd1};
    send_frame(frm, 1'b1, 8'h80, 8'h7F, 7'd127);
    // A head byte of 96 still gets the acknowledge; forward the frame as is.
    frm = '{8'd96, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd128};
    send_frame(frm, 1'b0, 8'h7F, 8'h80, 7'd0);

    // Random frames; two frames in each ten run without any idling.
    for (int f = 0; f < RandFrames; f++) begin
      steady = (f % 10 == 6) || (f % 10 == 7);
      r = $urandom_range(0, 99);
      for (int i = 1; i < FrameBytes; i++) frm[i] = pick_byte();
      frm[0] = (r < 40) ? jfi_pkg::HsOpcode : (r < 55) ? 8'd96 : pick_byte();
      send_frame(frm, 1'($urandom_range(0, 1)), pick_byte(), pick_byte(),
                 7'(pick_byte() >> 1));
    end
    steady = 1'b0;
    push <= 1'b0;

    // Drain: wait for every predicted byte, then keep watching for strays.
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d frames (%0d handshake, %0d robot control) and checked %0d result bytes",
             frames_sent, frames_hs, frames_bot, checked);
    $display("Mismatches or stray results: %0d", fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
